[src/assert_macros.svh]
// ------------------------------------------------------------------------
// assert_macros
// Assertion helpers for the RTL.
// ------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge, disabled in reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

[src/fas_pkg.sv]
// ------------------------------------------------------------------------
// fas_pkg
// Shared constants for the truncating float32 add/sub core.
// ------------------------------------------------------------------------
package fas_pkg;
    localparam int unsigned ExpW  = 8;
    localparam int unsigned FracW = 23;
    localparam int unsigned SigW  = 24;
    localparam int unsigned ShiftLimit = 25;
    localparam logic [ExpW-1:0] ExpMax = 8'hFF;
    localparam logic CmdAdd = 1'b0;
    localparam logic CmdSub = 1'b1;

    // Leading-zero count of a 24-bit value (0..24).
    function automatic logic [4:0] lzc24(input logic [SigW-1:0] v);
        logic [4:0] n;
        n = 5'd24;
        for (int i = 0; i < SigW; i++) begin
            if (v[i]) begin
                n = 5'(SigW - 1 - i);
            end
        end
        return n;
    endfunction
endpackage

[src/float32_add_sub_truncating_core.sv]
// ------------------------------------------------------------------------
// float32_add_sub_truncating_core
// Four-stage pipelined IEEE-754 single add/sub with truncation.
// ------------------------------------------------------------------------
// Path: an accepted item passes stage registers 1, 2, 3 and 4 in turn; o_valid is stage 4's valid bit.
// Throughput: one item per cycle; a stall freezes all stages together.
// Stages: compare/swap, align shift, add/sub, normalize and pack.
// Reset: synchronous active-low i_rst_n clears all stage valid bits.
module float32_add_sub_truncating_core
    import fas_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_cmd,
    input  logic [31:0] i_operand_a,
    input  logic [31:0] i_operand_b,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_sum_word,
    output logic        o_range_error
);
`include "assert_macros.svh"

    // whole pipe advances unless output is full and stalled
    logic w_adv;
    assign w_adv   = !(o_valid && i_stall);
    assign o_stall = !w_adv;

    // stage 1: operand swap by magnitude, zero bypass detection
    logic        r_v1, r_byp1, r_sgn1, r_unl1;
    logic [31:0] r_bypw1;
    logic [7:0]  r_eg1, r_d1;
    logic [23:0] r_mg1, r_ml1;

    // stage 2: aligned small significand and borrow
    logic        r_v2, r_byp2, r_sgn2, r_unl2, r_bor2;
    logic [31:0] r_bypw2;
    logic [7:0]  r_eg2;
    logic [23:0] r_mg2, r_sh2;

    // stage 3: raw sum
    logic        r_v3, r_byp3, r_sgn3;
    logic [31:0] r_bypw3;
    logic [7:0]  r_eg3;
    logic [24:0] r_m3;

    // stage 4: output register
    logic        r_v4, r_err4;
    logic [31:0] r_w4;

    logic [31:0] n_b, n_big, n_lit, n_bypw;
    logic [7:0]  n_ea, n_eb;
    logic        n_byp, n_swap;
    always_comb begin
        n_b    = i_operand_b ^ {i_cmd == CmdSub, 31'd0};
        n_ea   = i_operand_a[30:23];
        n_eb   = n_b[30:23];
        n_byp  = (n_ea == 8'd0) || (n_eb == 8'd0);
        n_bypw = (n_ea == 8'd0) ? ((n_eb == 8'd0) ? 32'd0 : n_b) : i_operand_a;
        n_swap = n_b[30:0] > i_operand_a[30:0];
        n_big  = n_swap ? n_b : i_operand_a;
        n_lit  = n_swap ? i_operand_a : n_b;
    end

    logic [23:0] n_sh;
    logic        n_bor;
    always_comb begin
        n_sh  = 24'd0;
        n_bor = 1'b0;
        if (r_d1 < 8'(ShiftLimit)) begin
            n_sh = r_ml1 >> r_d1[4:0];
            if (r_d1 != 8'd0) begin
                n_bor = r_ml1[5'(r_d1[4:0] - 5'd1)];
            end
        end
    end

    logic [4:0]  n_lz;
    logic [24:0] n_mn;
    logic [9:0]  n_e;
    logic [31:0] n_w;
    logic        n_err;
    always_comb begin
        n_lz  = lzc24(r_m3[23:0]);
        n_mn  = r_m3[24] ? (r_m3 >> 1) : (r_m3 << n_lz);
        n_e   = r_m3[24] ? ({2'b00, r_eg3} + 10'd1) : ({2'b00, r_eg3} - {5'd0, n_lz});
        n_err = 1'b0;
        if (r_byp3) begin
            n_w = r_bypw3;
        end else if (r_m3 == 25'd0) begin
            n_w = 32'd0;
        end else if (!n_e[9] && n_e[8:0] >= {1'b0, ExpMax}) begin
            n_w   = {r_sgn3, ExpMax, 23'd0};
            n_err = 1'b1;
        end else if (n_e[9] || n_e == 10'd0) begin
            n_w   = 32'd0;
            n_err = 1'b1;
        end else begin
            n_w = {r_sgn3, n_e[7:0], n_mn[22:0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (w_adv) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
        if (w_adv) begin
            r_byp1  <= n_byp;
            r_bypw1 <= n_bypw;
            r_sgn1  <= n_big[31];
            r_unl1  <= n_big[31] ^ n_lit[31];
            r_eg1   <= n_big[30:23];
            r_d1    <= n_big[30:23] - n_lit[30:23];
            r_mg1   <= {1'b1, n_big[22:0]};
            r_ml1   <= {1'b1, n_lit[22:0]};

            r_byp2  <= r_byp1;
            r_bypw2 <= r_bypw1;
            r_sgn2  <= r_sgn1;
            r_unl2  <= r_unl1;
            r_eg2   <= r_eg1;
            r_mg2   <= r_mg1;
            r_sh2   <= n_sh;
            r_bor2  <= n_bor;

            r_byp3  <= r_byp2;
            r_bypw3 <= r_bypw2;
            r_sgn3  <= r_sgn2;
            r_eg3   <= r_eg2;
            r_m3    <= r_unl2 ? ({1'b0, r_mg2} - {1'b0, r_sh2} - {24'd0, r_bor2})
                              : ({1'b0, r_mg2} + {1'b0, r_sh2});

            r_w4    <= n_w;
            r_err4  <= n_err;
        end
    end

    assign o_valid       = r_v4;
    assign o_sum_word    = r_w4;
    assign o_range_error = r_err4;

    `ASSERT_IMPL(a_stall_only_full, i_clk, i_rst_n, o_stall, o_valid)
    `ASSERT_NEXT(a_hold_stalled, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_sum_word))
    `ASSERT_IMPL(a_err_form, i_clk, i_rst_n, o_valid && o_range_error,
        o_sum_word[22:0] == 23'd0)
endmodule
